/* design/nmr_pkg.sv */
// ----------------------------------------------------------------------------
// nmr_pkg
// Shared types and constants for the name to port registry: item structs,
// status codes, name width and the preloaded first entry.
// ----------------------------------------------------------------------------
`default_nettype none

package nmr_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int NAME_BYTES        = 32;
    localparam int NAME_BITS         = 256;
    localparam int PORT_BITS         = 31;

    typedef logic [NAME_BITS-1:0] name_t;
    typedef logic [PORT_BITS-1:0] port_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // entry 0 after reset: "namer" with port 1
    localparam name_t FIRST_NAME = NAME_BITS'(64'h0000_0072_656d_616e);
    localparam port_t FIRST_PORT = PORT_BITS'(1);

    typedef struct packed {
        port_t       port_number;
        logic [63:0] name_bytes_0_7;
        logic [63:0] name_bytes_8_15;
        logic [63:0] name_bytes_16_23;
        logic [63:0] name_bytes_24_31;
    } request_t;

    typedef struct packed {
        status_t status;
        port_t   found_port;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

/* design/nmr_name_norm.sv */
// ----------------------------------------------------------------------------
// nmr_name_norm
// Name normalisation: clears byte 31 and every byte after the first zero
// byte, so that whole-word equality matches string equality.
// ----------------------------------------------------------------------------
`default_nettype none

module nmr_name_norm (
    input  wire nmr_pkg::request_t request,
    output nmr_pkg::name_t         name
);
    import nmr_pkg::*;

    logic [NAME_BYTES-1:0][7:0] raw;
    logic [NAME_BYTES-1:0][7:0] clean;
    logic [NAME_BYTES-1:0]      is_zero;
    logic [NAME_BYTES-1:0]      ended;

    assign raw = {request.name_bytes_24_31, request.name_bytes_16_23,
                  request.name_bytes_8_15, request.name_bytes_0_7};

    always_comb
    begin
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            is_zero[b] = (raw[b] == 8'd0) || (b == NAME_BYTES - 1);
        end
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            // any terminator below this byte
            ended[b] = |(is_zero & ((NAME_BYTES'(1) << b) - NAME_BYTES'(1)));
            clean[b] = (ended[b] || (b == NAME_BYTES - 1)) ? 8'd0 : raw[b];
        end
    end

    assign name = clean;

endmodule

`default_nettype wire

/* design/nmr_table.sv */
// ----------------------------------------------------------------------------
// nmr_table
// Name and port memories, one row per entry, with a registered (synchronous)
// read. Entry 0 is the fixed preload and is never written.
// ----------------------------------------------------------------------------
`default_nettype none

module nmr_table #(
    parameter int TABLE_ENTRIES = nmr_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_BITS      = $clog2(TABLE_ENTRIES)
) (
    input  wire                    clk,
    input  wire nmr_pkg::mem_ctl_t ctl,
    input  wire [IDX_BITS-1:0]     rd_addr,
    input  wire [IDX_BITS-1:0]     wr_addr,
    input  wire nmr_pkg::name_t    wr_name,
    input  wire nmr_pkg::port_t    wr_port,
    output nmr_pkg::name_t         rd_name,
    output nmr_pkg::port_t         rd_port
);
    import nmr_pkg::*;

    name_t name_mem [TABLE_ENTRIES];
    port_t port_mem [TABLE_ENTRIES];

    name_t name_q_reg;
    port_t port_q_reg;
    logic  first_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            name_mem[wr_addr] <= wr_name;
            port_mem[wr_addr] <= wr_port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            name_q_reg <= name_mem[rd_addr];
            port_q_reg <= port_mem[rd_addr];
            first_reg  <= (rd_addr == '0);
        end
    end

    assign rd_name = first_reg ? FIRST_NAME : name_q_reg;
    assign rd_port = first_reg ? FIRST_PORT : port_q_reg;

endmodule

`default_nettype wire

/* design/nmr_ctrl.sv */
// ----------------------------------------------------------------------------
// nmr_ctrl
// Request sequencer: walks the used entries one read per cycle, compares
// the returned row, and appends on a successful register.
// ----------------------------------------------------------------------------
`default_nettype none

module nmr_ctrl #(
    parameter int TABLE_ENTRIES = nmr_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_BITS      = $clog2(TABLE_ENTRIES),
    parameter int CNT_BITS      = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire nmr_pkg::port_t    port_in,
    input  wire nmr_pkg::name_t    name_in,
    output logic                   busy,
    output logic                   done,
    output nmr_pkg::result_t       result,
    output nmr_pkg::mem_ctl_t      ctl,
    output logic [IDX_BITS-1:0]    rd_addr,
    output logic [IDX_BITS-1:0]    wr_addr,
    output nmr_pkg::name_t         wr_name,
    output nmr_pkg::port_t         wr_port,
    input  wire nmr_pkg::name_t    rd_name,
    input  wire nmr_pkg::port_t    rd_port
);
    import nmr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;
    name_t               key_reg;
    port_t               port_reg;

    logic is_register;
    logic hit;
    logic finish;
    logic full;

    always_comb
    begin
        is_register = (port_reg != '0);
        ctl.rd_en   = (state_reg == S_SCAN) && (idx_reg < count_reg);
        hit         = cmp_valid_reg &&
                      (is_register ? (rd_port == port_reg) : (rd_name == key_reg));
        finish      = (state_reg == S_SCAN) && !cmp_valid_reg && !ctl.rd_en;
        full        = (count_reg == CNT_BITS'(TABLE_ENTRIES));
        ctl.wr_en   = finish && is_register && !full;

        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        cmp_valid_next = 1'b0;
        done_next      = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                cmp_valid_next = ctl.rd_en;
                if (ctl.rd_en)
                begin
                    idx_next = idx_reg + CNT_BITS'(1);
                end
                if (hit)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.status = is_register ? ST_DUP : ST_OK;
                    result_next.found_port = is_register ? '0 : rd_port;
                end
                else if (finish)
                begin
                    state_next             = S_IDLE;
                    done_next              = 1'b1;
                    result_next.found_port = '0;
                    result_next.status     = ST_OK;
                    if (is_register && full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    if (ctl.wr_en)
                    begin
                        count_next = count_reg + CNT_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= CNT_BITS'(1);
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && (state_reg == S_IDLE))
        begin
            key_reg  <= name_in;
            port_reg <= port_in;
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;
    assign rd_addr = idx_reg[IDX_BITS-1:0];
    assign wr_addr = count_reg[IDX_BITS-1:0];
    assign wr_name = key_reg;
    assign wr_port = port_reg;

endmodule

`default_nettype wire

/* design/name_to_port_registry.sv */
// Sequence: an accepted item reads the used entries in order, one row per
// cycle, compares each registered row, and stops at the first match or after
// the last used entry; status and port then come out with the done strobe.
// Items are handled one at a time; a new start is taken only while idle.
// Reset: the table holds only entry 0 ("namer" -> 1); no clearing pass.
// Results are a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
// name_to_port_registry
// Append-only name to port table with linear search for register and
// lookup requests.
// ----------------------------------------------------------------------------
`default_nettype none

module name_to_port_registry #(
    parameter int TABLE_ENTRIES = nmr_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire nmr_pkg::request_t request,
    output logic                  busy,
    output logic                  done,
    output nmr_pkg::result_t      result
);
    import nmr_pkg::*;

    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

    name_t               norm_name;
    mem_ctl_t            ctl;
    logic [IDX_BITS-1:0] rd_addr;
    logic [IDX_BITS-1:0] wr_addr;
    name_t               wr_name;
    port_t               wr_port;
    name_t               rd_name;
    port_t               rd_port;

    nmr_name_norm u_norm (
        .request (request),
        .name    (norm_name)
    );

    nmr_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_BITS      (IDX_BITS),
        .CNT_BITS      (CNT_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .port_in (request.port_number),
        .name_in (norm_name),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_name (wr_name),
        .wr_port (wr_port),
        .rd_name (rd_name),
        .rd_port (rd_port)
    );

    nmr_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_BITS      (IDX_BITS)
    ) u_table (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_name (wr_name),
        .wr_port (wr_port),
        .rd_name (rd_name),
        .rd_port (rd_port)
    );

endmodule

`default_nettype wire

/* design/nmr_checker.sv */
// ----------------------------------------------------------------------------
// nmr_checker
// Port-level checks for the name to port registry, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nmr_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   start,
    input wire                   busy,
    input wire                   done,
    input wire nmr_pkg::result_t result
);
    import nmr_pkg::*;

    // an accepted item keeps the block busy for its scan
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted item");

    // a result only ends a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a finished item");

    // strobe is a single cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a found port only comes with an ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.found_port != '0)) |-> (result.status == ST_OK))
        else $error("found port with a refusal status");

endmodule

bind name_to_port_registry nmr_checker u_nmr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the name to port registry. A short table of
// directed requests is followed by random register and lookup traffic. A
// local copy of the table predicts status and port where no fixed result is
// given. Each done strobe is compared in order with the expected results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import nmr_pkg::*;

    localparam int     TABLE_ENTRIES = 32;
    localparam int     RANDOM_ITEMS  = 1500;
    localparam int     QUIET_ITEMS   = 200;
    localparam int     TAIL_CYCLES   = 40;
    localparam longint CYCLE_LIMIT   = 400000;
    localparam name_t  NAMER         = 256'h72_656d_616e;
    localparam port_t  PORT_MAX      = 31'h7fff_ffff;

    typedef struct {
        request_t req;
        bit       fixed;
        result_t  res;
    } row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;

    logic     fixed_valid;
    result_t  fixed_result;

    name_t       model_names[TABLE_ENTRIES];
    port_t       model_ports[TABLE_ENTRIES];
    int unsigned model_used;

    result_t pending_results[$];
    row_t    directed_rows[$];
    int      mismatch_count = 0;
    longint  cycle_count = 0;

    name_to_port_registry #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // bytes after the first zero are cleared, byte 31 is always zero
    function automatic name_t clean_name(name_t raw);
        name_t       n;
        bit          ended;
        logic [7:0]  b;
        int          i;
        n     = '0;
        ended = 1'b0;
        for (i = 0; i < NAME_BYTES; i++)
        begin
            b = raw[8*i +: 8];
            if (i == NAME_BYTES - 1 || ended)
                b = 8'h00;
            if (b == 8'h00)
                ended = 1'b1;
            n[8*i +: 8] = b;
        end
        return n;
    endfunction

    function automatic result_t registry_apply(request_t r);
        result_t res;
        name_t   key;
        int      i;
        res.status     = ST_OK;
        res.found_port = '0;
        key = clean_name({r.name_bytes_24_31, r.name_bytes_16_23,
                          r.name_bytes_8_15, r.name_bytes_0_7});
        if (r.port_number != '0)
        begin
            for (i = 0; i < model_used; i++)
                if (model_ports[i] == r.port_number)
                begin
                    res.status = ST_DUP;
                    return res;
                end
            if (model_used >= TABLE_ENTRIES)
            begin
                res.status = ST_FULL;
                return res;
            end
            model_ports[model_used] = r.port_number;
            model_names[model_used] = key;
            model_used++;
            return res;
        end
        for (i = 0; i < model_used; i++)
            if (model_names[i] == key)
            begin
                res.found_port = model_ports[i];
                return res;
            end
        return res;
    endfunction

    function automatic request_t make_request(port_t p, name_t n);
        request_t r;
        r.port_number      = p;
        r.name_bytes_0_7   = n[63:0];
        r.name_bytes_8_15  = n[127:64];
        r.name_bytes_16_23 = n[191:128];
        r.name_bytes_24_31 = n[255:192];
        return r;
    endfunction

    function automatic name_t text_name(string s);
        name_t n;
        int    i;
        n = '0;
        for (i = 0; i < s.len() && i < NAME_BYTES; i++)
            n[8*i +: 8] = s[i];
        return n;
    endfunction

    function automatic void add_row(port_t p, name_t n, bit fixed,
                                    status_t s = ST_OK, port_t f = '0);
        row_t row;
        row.req            = make_request(p, n);
        row.fixed          = fixed;
        row.res.status     = s;
        row.res.found_port = f;
        directed_rows.push_back(row);
    endfunction

    function automatic name_t random_name();
        name_t n;
        int    len;
        int    i;
        n   = '0;
        len = $urandom_range(0, NAME_BYTES);
        for (i = 0; i < NAME_BYTES; i++)
            if (i < len)
                n[8*i +: 8] = 8'($urandom_range(1, 255));
            else if (i > len && $urandom_range(0, 1) == 1)
                n[8*i +: 8] = 8'($urandom);
        return n;
    endfunction

    function automatic request_t random_request();
        int    pick;
        port_t p;
        name_t n;
        bit    ended;
        int    i;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            p = ($urandom_range(0, 9) == 0) ? port_t'($urandom_range(1, 40))
                                            : port_t'($urandom);
            if (p == '0)
                p = PORT_MAX;
            return make_request(p, random_name());
        end
        if (pick < 50)
            return make_request(model_ports[$urandom_range(0, model_used - 1)],
                                random_name());
        if (pick < 85)
        begin
            // stored name with junk after its terminator
            n     = model_names[$urandom_range(0, model_used - 1)];
            ended = 1'b0;
            for (i = 0; i < NAME_BYTES; i++)
                if (ended)
                begin
                    if ($urandom_range(0, 1) == 1)
                        n[8*i +: 8] = 8'($urandom);
                end
                else if (n[8*i +: 8] == 8'h00)
                    ended = 1'b1;
            return make_request('0, n);
        end
        return make_request('0, random_name());
    endfunction

    task automatic note_failure(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", what);
    endtask

    task automatic send_item(request_t r, bit fixed, result_t fr, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request      <= r;
        fixed_valid  <= fixed;
        fixed_result <= fr;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic int idle_burst(bit quiet);
        if (quiet || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t predicted;
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    note_failure($sformatf("unexpected item: status %0d port %0h",
                                           result.status, result.found_port));
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status ||
                        result.found_port !== want.found_port)
                        note_failure($sformatf(
                            "mismatch: status exp %0d got %0d, port exp %0h got %0h",
                            want.status, result.status,
                            want.found_port, result.found_port));
                end
            end
            if (start && !busy)
            begin
                predicted = registry_apply(request);
                pending_results.push_back(fixed_valid ? fixed_result : predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        result_t none;
        int      i;
        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        fixed_valid    = 1'b0;
        fixed_result   = '0;
        none           = '0;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            model_names[i] = '0;
            model_ports[i] = '0;
        end
        model_names[0] = NAMER;
        model_ports[0] = 31'd1;
        model_used     = 1;

        add_row('0, text_name("namer"), 1'b1, ST_OK, 31'd1);
        add_row(31'd1, text_name("dupe"), 1'b1, ST_DUP);
        add_row('0, '0, 1'b1, ST_OK, '0);
        add_row('0, text_name("name"), 1'b1, ST_OK, '0);
        add_row(PORT_MAX, '1, 1'b1, ST_OK);
        add_row('0, {8'h00, {31{8'hff}}}, 1'b1, ST_OK, PORT_MAX);
        add_row(31'd2, '0, 1'b1, ST_OK);
        add_row('0, {{31{8'ha5}}, 8'h00}, 1'b0);
        add_row(31'd3, text_name("namer"), 1'b1, ST_OK);
        add_row('0, NAMER | (256'h5a3c_c3ff << 48), 1'b0);
        add_row(PORT_MAX, text_name("other"), 1'b1, ST_DUP);
        add_row(31'h4000_0000, text_name("namer2"), 1'b0);
        add_row('0, text_name("namer2"), 1'b0);
        add_row(31'h2aaa_aaaa, {16{16'h55aa}}, 1'b0);
        add_row(31'h5555_5555, {32{8'h80}}, 1'b0);
        add_row('0, {32{8'h80}}, 1'b0);
        add_row('0, text_name("zzz"), 1'b1, ST_OK, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[k])
            send_item(directed_rows[k].req, directed_rows[k].fixed,
                      directed_rows[k].res, idle_burst(1'b0));
        wait_for_results();

        // random traffic
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_for_results();
            send_item(random_request(), 1'b0, none,
                      idle_burst(i >= RANDOM_ITEMS - QUIET_ITEMS));
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d items never returned", pending_results.size()));

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/nmr_pkg.sv
design/nmr_name_norm.sv
design/nmr_table.sv
design/nmr_ctrl.sv
design/name_to_port_registry.sv
design/nmr_checker.sv
tb/tb_top.sv
